// ===== rtl/pwsg_pkg.sv =====
// Shared widths, register indexes and constants of the waveform sample generator.
package pwsg_pkg;

	localparam int unsigned INDEX_W    = 16;
	localparam int unsigned SAMPLE_W   = 32;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned LEVEL_W    = 32;
	localparam int unsigned PERIOD_W   = 16;
	localparam int unsigned SYM_W      = 7;
	localparam int unsigned BITLEN_W   = 6;
	localparam int unsigned WAVE_W     = 2;
	localparam int unsigned SINE_FRAC  = 17;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [WAVE_W-1:0]    wave_t;

	localparam cfg_idx_t REG_WAVE_TYPE        = 3'd0;
	localparam cfg_idx_t REG_CONSTANT_LEVEL   = 3'd1;
	localparam cfg_idx_t REG_LOW_LEVEL        = 3'd2;
	localparam cfg_idx_t REG_HIGH_LEVEL       = 3'd3;
	localparam cfg_idx_t REG_PERIOD_SAMPLES   = 3'd4;
	localparam cfg_idx_t REG_SYMMETRY_PERCENT = 3'd5;
	localparam cfg_idx_t REG_BIT_LENGTH       = 3'd6;

	localparam wave_t WAVE_CONST  = 2'd0;
	localparam wave_t WAVE_SQUARE = 2'd1;
	localparam wave_t WAVE_SINE   = 2'd2;
	localparam wave_t WAVE_RAMP   = 2'd3;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1;
	localparam logic [SYM_W-1:0]    SYM_RESET    = 7'd50;
	localparam logic [SYM_W-1:0]    SYM_MAX      = 7'd100;
	localparam logic [BITLEN_W-1:0] BITLEN_RESET = 6'd16;
	localparam logic [BITLEN_W-1:0] BITLEN_BYTE  = 6'd8;
	localparam logic [BITLEN_W-1:0] BITLEN_HALF  = 6'd16;

	localparam logic [SAMPLE_W-1:0] MASK_1B = 32'h0000_00FF;
	localparam logic [SAMPLE_W-1:0] MASK_2B = 32'h0000_FFFF;
	localparam logic [SAMPLE_W-1:0] MASK_4B = 32'hFFFF_FFFF;

	// floor(2^32 / 100), used with one correction step for division by 100
	localparam int unsigned         RECIP_SHIFT = 32;
	localparam int unsigned         RECIP_W     = 26;
	localparam logic [RECIP_W-1:0]  RECIP_100   = 26'd42949672;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

// ===== rtl/pwsg_if.sv =====
// Valid/ready channel interfaces of the waveform sample generator.
interface pwsg_in_if import pwsg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] sample_index;

	modport source (output valid, output sample_index, input ready);
	modport sink (input valid, input sample_index, output ready);
endinterface

interface pwsg_out_if import pwsg_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_value;
	logic                index_out_of_range;

	modport source (output valid, output sample_value, output index_out_of_range, input ready);
	modport sink (input valid, input sample_value, input index_out_of_range, output ready);
endinterface

interface pwsg_cfg_if import pwsg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/periodic_waveform_sample_generator.sv =====
// Waveform sample generator: constant, square, sine and ramp samples, fully pipelined.
//
// Takes one sample index per cycle and returns one sample per cycle, in order, as long as
// results are taken. The pipeline is built around the 32-stage restoring divider that
// serves both the sine phase (index * 2^(SINE_TABLE_BITS+2) / period) and the ramp
// quotient, plus eight stages ahead of it (ramp breakpoint, two multiplies, magnitude)
// and three behind it (quarter-wave ROM read, sine multiply, offset add). A two-entry
// output buffer keeps the input side open while one result waits to be taken; when it
// holds two, the whole pipeline stalls. The sine ROM holds 2^SINE_TABLE_BITS + 1 entries
// in Q1.17 and is built at elaboration. Registers are written through the cfg channel,
// which is always ready; write them only while no index is in flight.
module periodic_waveform_sample_generator import pwsg_pkg::*; #(
	parameter int unsigned SINE_TABLE_BITS   = 10,
	parameter int unsigned PERIOD_INDEX_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	pwsg_in_if.sink    sample,
	pwsg_out_if.source result,
	pwsg_cfg_if.sink   cfg
);

	localparam int unsigned TB        = SINE_TABLE_BITS;
	localparam int unsigned PB        = PERIOD_INDEX_BITS;
	localparam int unsigned PH_W      = TB + 2;
	localparam int unsigned ROM_N     = (1 << TB) + 1;
	localparam int unsigned ROM_AW    = TB + 1;
	localparam int unsigned DIV_STEPS = SAMPLE_W;
	localparam int unsigned DW        = PB + DIV_STEPS;
	localparam int unsigned M_W       = SYM_W + PB;
	localparam int unsigned RP_W      = M_W + RECIP_W;
	localparam int unsigned PA_W      = LEVEL_W + PB + 1;
	localparam int unsigned PRODB_W   = LEVEL_W + PB + 2;
	localparam int unsigned ACC_W     = PRODB_W + 1;
	localparam int unsigned SQ_W      = SINE_FRAC + 2;
	localparam int unsigned SPROD_W   = LEVEL_W + 1 + SQ_W;
	localparam int unsigned SACC_W    = SPROD_W + 1;
	localparam int unsigned SCALE_SH  = 30 - SINE_FRAC;

	typedef logic [SINE_FRAC:0] rom_t [ROM_N];

	typedef struct packed {
		logic oor;
		logic hi;
		logic neg;
	} tag_t;

	function automatic logic [SINE_FRAC:0] sine_entry(input int unsigned k);
		logic [63:0] x;
		logic [63:0] term;
		longint      sum;
		int unsigned n;
		logic        minus;
		longint      q;
		x = (HALF_PI_Q30 * 64'(k) + (64'd1 << (TB - 1))) >> TB;
		sum = longint'(x);
		term = x;
		minus = 1'b1;
		for (n = 1; n < 20; n++) begin
			if (term != 64'd0) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / 64'((2 * n) * (2 * n + 1));
				if (minus) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
				minus = !minus;
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		q = (sum + (longint'(1) << (SCALE_SH - 1))) >>> SCALE_SH;
		if (q > (longint'(1) << SINE_FRAC)) begin
			q = longint'(1) << SINE_FRAC;
		end
		return (SINE_FRAC + 1)'(q);
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		for (int k = 0; k < ROM_N; k++) begin
			r[k] = sine_entry(unsigned'(k));
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// configuration registers
	wave_t                      wave_type_q;
	logic signed [LEVEL_W-1:0]  constant_level_q;
	logic signed [LEVEL_W-1:0]  low_level_q;
	logic signed [LEVEL_W-1:0]  high_level_q;
	logic [PERIOD_W-1:0]        period_samples_q;
	logic [SYM_W-1:0]           symmetry_percent_q;
	logic [BITLEN_W-1:0]        bit_length_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_type_q        <= WAVE_CONST;
			constant_level_q   <= '0;
			low_level_q        <= '0;
			high_level_q       <= '0;
			period_samples_q   <= PERIOD_RESET;
			symmetry_percent_q <= SYM_RESET;
			bit_length_q       <= BITLEN_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_WAVE_TYPE:        wave_type_q        <= cfg.data[WAVE_W-1:0];
				REG_CONSTANT_LEVEL:   constant_level_q   <= cfg.data[LEVEL_W-1:0];
				REG_LOW_LEVEL:        low_level_q        <= cfg.data[LEVEL_W-1:0];
				REG_HIGH_LEVEL:       high_level_q       <= cfg.data[LEVEL_W-1:0];
				REG_PERIOD_SAMPLES:   period_samples_q   <= cfg.data[PERIOD_W-1:0];
				REG_SYMMETRY_PERCENT: symmetry_percent_q <= cfg.data[SYM_W-1:0];
				REG_BIT_LENGTH:       bit_length_q       <= cfg.data[BITLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// values derived from the registers, steady while items are in flight as long as no register is written then
	logic [PB-1:0]             period_n;
	logic signed [LEVEL_W:0]   level_diff;
	logic [SYM_W-1:0]          sym_sat;

	assign period_n   = PB'(period_samples_q);
	assign level_diff = (LEVEL_W + 1)'(high_level_q) - (LEVEL_W + 1)'(low_level_q);
	assign sym_sat    = (symmetry_percent_q > SYM_MAX) ? SYM_MAX : symmetry_percent_q;

	// pipeline control
	logic [1:0] skid_cnt_q;
	logic       en;
	logic       accept;

	assign en           = (skid_cnt_q != 2'd2);
	assign sample.ready = en;
	assign accept       = sample.valid && en;

	// front stage signals
	logic [PB-1:0]  idx_in;
	logic [PB-1:0]  n_eff;
	logic [M_W-1:0] m_calc;

	assign idx_in = PB'(sample.sample_index);
	assign n_eff  = (wave_type_q == WAVE_CONST) ? PB'(1) : period_n;
	assign m_calc = M_W'(sym_sat) * M_W'(period_n);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_t1, v_t2, v_t3;

	logic [PB-1:0]              idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6, idx_s7;
	logic                       oor_s1, oor_s2, oor_s3, oor_s4, oor_s5, oor_s6, oor_s7;
	logic [M_W-1:0]             m_s1, m_s2;
	logic [PB-1:0]              q0_s2;
	logic [PB-1:0]              x_s3;
	logic                       rising_s4, rising_s5, rising_s6;
	logic                       hi_s4, hi_s5, hi_s6, hi_s7;
	logic [PB-1:0]              den_s4, den_s5, den_s6, den_s7;
	logic [PB-1:0]              j_s4, j_s5;
	logic signed [PA_W-1:0]     proda_s5, proda_s6;
	logic signed [PRODB_W-1:0]  prodb_s6;
	logic signed [ACC_W-1:0]    acc_s7;

	// combinational pieces between front stages
	logic [RP_W-1:0]            recip_prod;
	logic [M_W-1:0]             rem100;
	logic [PB-1:0]              x_calc;
	logic                       rising_calc;
	logic signed [LEVEL_W-1:0]  base_lvl;
	logic signed [PA_W-1:0]     proda_calc;
	logic signed [PRODB_W-1:0]  prodb_calc;
	logic signed [ACC_W-1:0]    acc_calc;
	logic                       acc_neg;
	logic signed [ACC_W-1:0]    acc_mag;
	logic [DW-1:0]              dividend;
	logic [PB-1:0]              divisor;

	assign recip_prod  = RP_W'(m_s1) * RP_W'(RECIP_100);
	assign rem100      = m_s2 - M_W'(q0_s2) * M_W'(SYM_MAX);
	assign x_calc      = q0_s2 + PB'(rem100 >= M_W'(SYM_MAX));
	assign rising_calc = idx_s3 < x_s3;
	assign base_lvl    = rising_s4 ? low_level_q : high_level_q;
	assign proda_calc  = base_lvl * $signed({1'b0, den_s4});
	assign prodb_calc  = level_diff * $signed({1'b0, j_s5});
	assign acc_calc    = rising_s6 ? ACC_W'(proda_s6) + ACC_W'(prodb_s6)
	                               : ACC_W'(proda_s6) - ACC_W'(prodb_s6);
	assign acc_neg     = acc_s7[ACC_W-1];
	assign acc_mag     = acc_neg ? -acc_s7 : acc_s7;
	assign dividend    = (wave_type_q == WAVE_SINE) ? (DW'(idx_s7) << PH_W)
	                                                : DW'($unsigned(acc_mag));
	assign divisor     = (wave_type_q == WAVE_SINE) ? period_n : den_s7;

	// divider stages; stage 0 is loaded from the front pipeline
	logic                 div_v_s   [DIV_STEPS+1];
	logic [PB-1:0]        div_rem_s [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] div_quo_s [DIV_STEPS+1];
	logic [PB-1:0]        div_den_s [DIV_STEPS+1];
	tag_t                 div_tag_s [DIV_STEPS+1];

	logic [PB:0]          div_trial [DIV_STEPS+1];
	logic                 div_ge    [DIV_STEPS+1];
	logic [PB-1:0]        div_rem_nx[DIV_STEPS+1];

	always_comb begin
		for (int k = 0; k <= DIV_STEPS; k++) begin
			div_trial[k]  = {div_rem_s[k], div_quo_s[k][DIV_STEPS-1]};
			div_ge[k]     = div_trial[k] >= {1'b0, div_den_s[k]};
			div_rem_nx[k] = div_ge[k] ? PB'(div_trial[k] - {1'b0, div_den_s[k]})
			                          : PB'(div_trial[k]);
		end
	end

	// back stages
	logic [DIV_STEPS-1:0]       quo_fin;
	logic [PH_W-1:0]            phase;
	logic [ROM_AW-1:0]          rom_addr;
	logic [SINE_FRAC:0]         rom_t1;
	logic                       sneg_t1;
	logic [DIV_STEPS-1:0]       quo_t1;
	tag_t                       tag_t1, tag_t2, tag_t3;
	logic signed [SQ_W-1:0]     sine_s;
	logic signed [SPROD_W-1:0]  sprod_calc;
	logic signed [SPROD_W-1:0]  sprod_t2;
	logic [SAMPLE_W-1:0]        rampv_calc;
	logic [SAMPLE_W-1:0]        rampv_t2, rampv_t3;
	logic signed [SACC_W-1:0]   sacc_t3;

	assign quo_fin    = div_quo_s[DIV_STEPS];
	assign phase      = quo_fin[PH_W-1:0];
	// odd quadrants read the table mirrored
	assign rom_addr   = phase[TB] ? (ROM_AW'(1) << TB) - ROM_AW'(phase[TB-1:0])
	                              : ROM_AW'(phase[TB-1:0]);
	assign sine_s     = sneg_t1 ? -$signed({1'b0, rom_t1}) : $signed({1'b0, rom_t1});
	assign sprod_calc = level_diff * sine_s;
	assign rampv_calc = tag_t1.neg ? SAMPLE_W'(-quo_t1) : SAMPLE_W'(quo_t1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int k = 0; k <= DIV_STEPS; k++) begin
				div_v_s[k] <= 1'b0;
			end
			v_t1 <= 1'b0;
			v_t2 <= 1'b0;
			v_t3 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			div_v_s[0] <= v_s7;
			for (int k = 1; k <= DIV_STEPS; k++) begin
				div_v_s[k] <= div_v_s[k-1];
			end
			v_t1 <= div_v_s[DIV_STEPS];
			v_t2 <= v_t1;
			v_t3 <= v_t2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= idx_in;
			oor_s1 <= idx_in >= n_eff;
			m_s1   <= m_calc;

			idx_s2 <= idx_s1;
			oor_s2 <= oor_s1;
			m_s2   <= m_s1;
			q0_s2  <= PB'(recip_prod >> RECIP_SHIFT);

			idx_s3 <= idx_s2;
			oor_s3 <= oor_s2;
			x_s3   <= x_calc;

			idx_s4    <= idx_s3;
			oor_s4    <= oor_s3;
			rising_s4 <= rising_calc;
			hi_s4     <= idx_s3 >= (period_n >> 1);
			den_s4    <= rising_calc ? x_s3 : period_n - x_s3;
			j_s4      <= rising_calc ? idx_s3 : idx_s3 - x_s3;

			idx_s5    <= idx_s4;
			oor_s5    <= oor_s4;
			rising_s5 <= rising_s4;
			hi_s5     <= hi_s4;
			den_s5    <= den_s4;
			j_s5      <= j_s4;
			proda_s5  <= proda_calc;

			idx_s6    <= idx_s5;
			oor_s6    <= oor_s5;
			rising_s6 <= rising_s5;
			hi_s6     <= hi_s5;
			den_s6    <= den_s5;
			proda_s6  <= proda_s5;
			prodb_s6  <= prodb_calc;

			idx_s7 <= idx_s6;
			oor_s7 <= oor_s6;
			hi_s7  <= hi_s6;
			den_s7 <= den_s6;
			acc_s7 <= acc_calc;

			// top bits of the dividend are already below the divisor
			div_rem_s[0] <= dividend[DW-1:DIV_STEPS];
			div_quo_s[0] <= dividend[DIV_STEPS-1:0];
			div_den_s[0] <= divisor;
			div_tag_s[0] <= '{oor: oor_s7, hi: hi_s7, neg: acc_neg};
			for (int k = 1; k <= DIV_STEPS; k++) begin
				div_rem_s[k] <= div_rem_nx[k-1];
				div_quo_s[k] <= {div_quo_s[k-1][DIV_STEPS-2:0], div_ge[k-1]};
				div_den_s[k] <= div_den_s[k-1];
				div_tag_s[k] <= div_tag_s[k-1];
			end

			rom_t1  <= SINE_ROM[rom_addr];
			sneg_t1 <= phase[TB+1];
			quo_t1  <= quo_fin;
			tag_t1  <= div_tag_s[DIV_STEPS];

			sprod_t2 <= sprod_calc;
			rampv_t2 <= rampv_calc;
			tag_t2   <= tag_t1;

			sacc_t3  <= (SACC_W'(low_level_q) <<< SINE_FRAC) + SACC_W'(sprod_t2);
			rampv_t3 <= rampv_t2;
			tag_t3   <= tag_t2;
		end
	end

	// final selection feeding the output buffer
	logic [SACC_W-1:0]   sbias;
	logic [SAMPLE_W-1:0] sine_v;
	logic [SAMPLE_W-1:0] raw_v;
	logic [SAMPLE_W-1:0] width_mask;
	logic [SAMPLE_W-1:0] new_value;
	logic                push;
	logic                pop;

	// bias negative sums so the shift truncates toward zero
	assign sbias  = sacc_t3 + (sacc_t3[SACC_W-1] ? SACC_W'((1 << SINE_FRAC) - 1) : SACC_W'(0));
	assign sine_v = sbias[SINE_FRAC +: SAMPLE_W];

	always_comb begin
		unique case (wave_type_q)
			WAVE_CONST:  raw_v = constant_level_q;
			WAVE_SQUARE: raw_v = tag_t3.hi ? high_level_q : low_level_q;
			WAVE_SINE:   raw_v = sine_v;
			WAVE_RAMP:   raw_v = rampv_t3;
			default:     raw_v = '0;
		endcase
		priority if (bit_length_q <= BITLEN_BYTE) begin
			width_mask = MASK_1B;
		end else if (bit_length_q <= BITLEN_HALF) begin
			width_mask = MASK_2B;
		end else begin
			width_mask = MASK_4B;
		end
		new_value = tag_t3.oor ? '0 : (raw_v & width_mask);
	end

	assign push = en && v_t3;
	assign pop  = result.valid && result.ready;

	logic [SAMPLE_W-1:0] sk0_value_q, sk1_value_q;
	logic                sk0_oor_q, sk1_oor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_cnt_q <= 2'd0;
		end else if (push && !pop) begin
			skid_cnt_q <= skid_cnt_q + 2'd1;
		end else if (pop && !push) begin
			skid_cnt_q <= skid_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				if (skid_cnt_q == 2'd0) begin
					sk0_value_q <= new_value;
					sk0_oor_q   <= tag_t3.oor;
				end else begin
					sk1_value_q <= new_value;
					sk1_oor_q   <= tag_t3.oor;
				end
			end
			2'b01: begin
				sk0_value_q <= sk1_value_q;
				sk0_oor_q   <= sk1_oor_q;
			end
			2'b11: begin
				// one entry held and leaving: the new result takes its place
				sk0_value_q <= new_value;
				sk0_oor_q   <= tag_t3.oor;
			end
			default: ;
		endcase
	end

	assign result.valid              = (skid_cnt_q != 2'd0);
	assign result.sample_value       = sk0_value_q;
	assign result.index_out_of_range = sk0_oor_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.index_out_of_range |-> result.sample_value == '0)
		else $error("out-of-range result carries a nonzero value");

	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (bit_length_q <= BITLEN_BYTE) |-> result.sample_value[SAMPLE_W-1:8] == '0)
		else $error("one-byte sample has bits above the byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> skid_cnt_q != 2'd2)
		else $error("output buffer written while full");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_v_s[DIV_STEPS] && !div_tag_s[DIV_STEPS].oor && (wave_type_q == WAVE_RAMP)
		|-> div_rem_s[DIV_STEPS] < div_den_s[DIV_STEPS])
		else $error("ramp divider remainder not below divisor");

endmodule
